// ===== src/pjd_pkg.sv =====
// Package: shared types and constants for the job dispatcher.
package pjd_pkg;
  localparam int Cpus         = 16;
  localparam int PendDepth    = 16;
  localparam int JobIdBits    = 8;
  localparam int CpuBits      = 4;
  localparam int CntBits      = 5;
  localparam int PrioBits     = 8;

  localparam logic CmdSubmit = 1'b0;
  localparam logic CmdFinish = 1'b1;

  typedef struct packed {
    logic [JobIdBits-1:0] job;
    logic [PrioBits-1:0]  prio;
    logic                 has_pref;
    logic [CpuBits-1:0]   pref;
  } entry_t;

  // Scan control from the top level to every cell.
  typedef struct packed {
    logic                 clear_best;  // start a new priority scan
    logic                 scan;        // cells compare on this cycle
    logic                 remove;      // remove the selected entry, shift up
    logic [CntBits-1:0]   sel_idx;     // index of entry to remove
  } cell_ctl_t;
endpackage

// ===== src/pjd_cell.sv =====
// One pending-store cell: holds an entry and passes the running best along the chain.
module pjd_cell (
  input  logic                        clk_i,
  input  logic [pjd_pkg::CntBits-1:0] idx_i,
  input  logic                        valid_i,      // this position is occupied
  input  logic                        wr_i,         // load write data
  input  pjd_pkg::entry_t             wr_entry_i,
  input  pjd_pkg::entry_t             next_entry_i, // from the cell behind, for shifting
  input  pjd_pkg::cell_ctl_t          ctl_i,
  input  logic                        best_vld_i,
  input  logic [pjd_pkg::PrioBits-1:0] best_prio_i,
  input  logic [pjd_pkg::CntBits-1:0] best_idx_i,
  output logic                        best_vld_o,
  output logic [pjd_pkg::PrioBits-1:0] best_prio_o,
  output logic [pjd_pkg::CntBits-1:0] best_idx_o,
  output pjd_pkg::entry_t             entry_o
);
  pjd_pkg::entry_t entry_q;
  logic            take;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      entry_q <= wr_entry_i;
    end else if (ctl_i.remove && (idx_i >= ctl_i.sel_idx)) begin
      entry_q <= next_entry_i;
    end
  end

  // strict greater keeps the earliest arrival on ties
  assign take        = valid_i && (!best_vld_i || (entry_q.prio > best_prio_i));
  assign best_vld_o  = best_vld_i || valid_i;
  assign best_prio_o = take ? entry_q.prio : best_prio_i;
  assign best_idx_o  = take ? idx_i : best_idx_i;
  assign entry_o     = entry_q;
endmodule

// ===== src/pjd_chain.sv =====
// Chain of pending cells with a registered best-candidate handoff every four cells.
module pjd_chain (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pjd_pkg::CntBits-1:0] count_i,
  input  logic                        wr_i,
  input  pjd_pkg::entry_t             wr_entry_i,
  input  pjd_pkg::cell_ctl_t          ctl_i,
  output logic [pjd_pkg::CntBits-1:0] best_idx_o,
  output pjd_pkg::entry_t             best_entry_o
);
  localparam int N = pjd_pkg::PendDepth;
  localparam int Seg = 4;

  logic                          bv   [N+1];
  logic [pjd_pkg::PrioBits-1:0]  bp   [N+1];
  logic [pjd_pkg::CntBits-1:0]   bi   [N+1];
  logic                          rv_q [N/Seg];
  logic [pjd_pkg::PrioBits-1:0]  rp_q [N/Seg];
  logic [pjd_pkg::CntBits-1:0]   ri_q [N/Seg];
  pjd_pkg::entry_t               ent  [N+1];

  assign ent[N] = '0;

  // scan is registered every Seg cells; the top waits out the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < N/Seg; s++) begin
        rv_q[s] <= 1'b0;
        rp_q[s] <= '0;
        ri_q[s] <= '0;
      end
    end else if (ctl_i.clear_best) begin
      for (int s = 0; s < N/Seg; s++) rv_q[s] <= 1'b0;
    end else if (ctl_i.scan) begin
      for (int s = 0; s < N/Seg; s++) begin
        rv_q[s] <= bv[(s+1)*Seg];
        rp_q[s] <= bp[(s+1)*Seg];
        ri_q[s] <= bi[(s+1)*Seg];
      end
    end
  end

  assign bv[0] = 1'b0;
  assign bp[0] = '0;
  assign bi[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic                          in_v;
    logic [pjd_pkg::PrioBits-1:0]  in_p;
    logic [pjd_pkg::CntBits-1:0]   in_i;
    if ((g % Seg) == 0 && g != 0) begin : g_reg
      assign in_v = rv_q[g/Seg-1];
      assign in_p = rp_q[g/Seg-1];
      assign in_i = ri_q[g/Seg-1];
    end else begin : g_comb
      assign in_v = bv[g];
      assign in_p = bp[g];
      assign in_i = bi[g];
    end
    pjd_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (pjd_pkg::CntBits'(g)),
      .valid_i     (pjd_pkg::CntBits'(g) < count_i),
      .wr_i        (wr_i && (count_i == pjd_pkg::CntBits'(g))),
      .wr_entry_i  (wr_entry_i),
      .next_entry_i(ent[g+1]),
      .ctl_i       (ctl_i),
      .best_vld_i  (in_v),
      .best_prio_i (in_p),
      .best_idx_i  (in_i),
      .best_vld_o  (bv[g+1]),
      .best_prio_o (bp[g+1]),
      .best_idx_o  (bi[g+1]),
      .entry_o     (ent[g])
    );
  end

  assign best_idx_o   = ri_q[N/Seg-1];
  assign best_entry_o = ent[ri_q[N/Seg-1]];
endmodule

// ===== src/priority_job_dispatcher.sv =====
// Top level: command decode, slot table and dispatch sequencer.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+---------------------------
//  command   | cmd_i job_id_i priority_req_i ...       | start && !busy
//  result    | started_o start_cpu_o ... last_o         | strobe_o, one cycle, no stall
//  config    | num_cpus_we_i num_cpus_i                 | write on num_cpus_we_i
//
// Sequence: a submit that does not end a batch keeps busy high through the empty
// state alone; a transaction that dispatches but starts nothing goes through check
// and empty. Each job start goes through check (clears the scan), scan (pushes the
// best candidate through the four registered cell segments) and done (commits);
// the serial scan through the chain sets its length. The last result shows in the
// cycle busy falls, so the next transaction may be accepted at the edge that takes it.
// Reset clears counts, slot busy bits and the sequencer; stored entries need none.
// The receiver cannot stall; busy stays high until the last result is issued.
module priority_job_dispatcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [7:0]  job_id_i,
  input  logic [7:0]  priority_req_i,
  input  logic        has_preference_i,
  input  logic [3:0]  preferred_cpu_i,
  input  logic        batch_last_i,
  input  logic [3:0]  finished_cpu_i,
  input  logic        num_cpus_we_i,
  input  logic [4:0]  num_cpus_i,
  output logic        strobe_o,
  output logic        started_o,
  output logic [3:0]  start_cpu_o,
  output logic [7:0]  start_job_id_o,
  output logic        dropped_o,
  output logic        bad_finish_o,
  output logic [4:0]  pending_count_o,
  output logic [4:0]  active_count_o,
  output logic        last_o
);
  localparam int Cb = pjd_pkg::CntBits;
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StDone  = 3'd3;
  localparam logic [2:0] StEmpty = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [2:0]              wait_q;
  logic [Cb-1:0]           ncpu_q, eff;
  logic [Cb-1:0]           pend_q, act_q;
  logic [pjd_pkg::Cpus-1:0] busy_q;
  logic                    drop_q, bad_q, any_q;
  logic                    free_found;
  logic [pjd_pkg::CpuBits-1:0] free_slot, slot;
  logic                    accept, do_wr, full;
  pjd_pkg::entry_t         wr_entry, best_e;
  pjd_pkg::cell_ctl_t      ctl;
  logic [Cb-1:0]           best_idx;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;
  assign full   = (pend_q >= Cb'(pjd_pkg::PendDepth));
  assign do_wr  = accept && (cmd_i == pjd_pkg::CmdSubmit) && !full;

  // effective CPU count clamped to 1..Cpus
  always_comb begin
    if (ncpu_q == '0) eff = Cb'(1);
    else if (ncpu_q > Cb'(pjd_pkg::Cpus)) eff = Cb'(pjd_pkg::Cpus);
    else eff = ncpu_q;
  end

  // lowest idle slot below eff
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = pjd_pkg::Cpus - 1; i >= 0; i--) begin
      if (!busy_q[i] && (Cb'(i) < eff)) begin
        free_found = 1'b1;
        free_slot  = pjd_pkg::CpuBits'(i);
      end
    end
  end

  always_comb begin
    slot = free_slot;
    if (best_e.has_pref && ({1'b0, best_e.pref} < eff) && !busy_q[best_e.pref]) begin
      slot = best_e.pref;
    end
  end

  assign wr_entry = '{job: job_id_i, prio: priority_req_i,
                      has_pref: has_preference_i, pref: preferred_cpu_i};

  always_comb begin
    ctl            = '0;
    ctl.clear_best = (state_q == StCheck);
    ctl.scan       = (state_q == StScan);
    ctl.remove     = (state_q == StDone);
    ctl.sel_idx    = best_idx;
  end

  pjd_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .count_i     (pend_q),
    .wr_i        (do_wr),
    .wr_entry_i  (wr_entry),
    .ctl_i       (ctl),
    .best_idx_o  (best_idx),
    .best_entry_o(best_e)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (cmd_i == pjd_pkg::CmdFinish || batch_last_i) state_d = StCheck;
          else state_d = StEmpty;
        end
      end
      StCheck: begin
        if (pend_q != '0 && free_found) state_d = StScan;
        else if (any_q) state_d = StIdle;
        else state_d = StEmpty;
      end
      StScan:  if (wait_q == 3'd3) state_d = StDone;
      StDone:  state_d = StCheck;
      StEmpty: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // a start is held until the next commit or the final check, which sets last
  logic       hold_q;
  logic [3:0] hcpu_q;
  logic [7:0] hjob_q;
  logic       emit_mid, emit_last, emit_empty;

  assign emit_mid   = (state_q == StDone) && hold_q;
  assign emit_last  = (state_q == StCheck) && !(pend_q != '0 && free_found) && hold_q;
  assign emit_empty = (state_q == StEmpty);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      wait_q   <= '0;
      ncpu_q   <= Cb'(pjd_pkg::Cpus);
      pend_q   <= '0;
      act_q    <= '0;
      busy_q   <= '0;
      drop_q   <= 1'b0;
      bad_q    <= 1'b0;
      any_q    <= 1'b0;
      hold_q   <= 1'b0;
      hcpu_q   <= '0;
      hjob_q   <= '0;
      strobe_o <= 1'b0;
      started_o <= 1'b0;
      start_cpu_o <= '0;
      start_job_id_o <= '0;
      dropped_o <= 1'b0;
      bad_finish_o <= 1'b0;
      pending_count_o <= '0;
      active_count_o <= '0;
      last_o <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_o <= emit_mid || emit_last || emit_empty;
      if (num_cpus_we_i) ncpu_q <= num_cpus_i;
      wait_q <= (state_q == StScan) ? wait_q + 3'd1 : '0;
      if (accept) begin
        any_q  <= 1'b0;
        drop_q <= (cmd_i == pjd_pkg::CmdSubmit) && full;
        bad_q  <= 1'b0;
        if (do_wr) pend_q <= pend_q + Cb'(1);
        if (cmd_i == pjd_pkg::CmdFinish) begin
          if (busy_q[finished_cpu_i]) begin
            busy_q[finished_cpu_i] <= 1'b0;
            act_q <= act_q - Cb'(1);
          end else begin
            bad_q <= 1'b1;
          end
        end
      end
      if (state_q == StDone) begin
        busy_q[slot] <= 1'b1;
        act_q  <= act_q + Cb'(1);
        pend_q <= pend_q - Cb'(1);
        any_q  <= 1'b1;
        hold_q <= 1'b1;
        hcpu_q <= slot;
        hjob_q <= best_e.job;
      end
      if (emit_last) hold_q <= 1'b0;
      // counts at this point already include the held start
      if (emit_mid || emit_last || emit_empty) begin
        started_o <= !emit_empty; last_o <= !emit_mid;
        start_cpu_o <= emit_empty ? '0 : hcpu_q;
        start_job_id_o <= emit_empty ? '0 : hjob_q;
        dropped_o <= drop_q; bad_finish_o <= bad_q;
        pending_count_o <= pend_q; active_count_o <= act_q;
      end
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the job dispatcher: directed table, then random traffic against a predictor.
module tb;
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       cmd_i = 1'b0;
  logic [7:0] job_id_i = '0;
  logic [7:0] priority_req_i = '0;
  logic       has_preference_i = 1'b0;
  logic [3:0] preferred_cpu_i = '0;
  logic       batch_last_i = 1'b0;
  logic [3:0] finished_cpu_i = '0;
  logic       num_cpus_we_i = 1'b0;
  logic [4:0] num_cpus_i = 5'd16;
  logic       strobe_o, started_o, dropped_o, bad_finish_o, last_o;
  logic [3:0] start_cpu_o;
  logic [7:0] start_job_id_o;
  logic [4:0] pending_count_o, active_count_o;

  priority_job_dispatcher DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  typedef struct packed {
    logic       started;
    logic [3:0] cpu;
    logic [7:0] job;
    logic       dropped;
    logic       bad;
    logic [4:0] pend;
    logic [4:0] act;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] job;
    logic [7:0] prio;
    logic       has_pref;
    logic [3:0] pref;
    logic       blast;
    logic [3:0] fcpu;
  } cmd_t;

  typedef struct packed {
    cmd_t c;
    logic chk;
    res_t exp;
  } row_t;

  // Predictor state.
  pjd_pkg::entry_t waitq[$];
  logic       slot_on[pjd_pkg::Cpus];
  logic [4:0] cpu_limit;
  int         act_n;
  res_t       expected_q[$];
  int         errors = 0;
  int         cycles = 0;

  function automatic int eff_cpus();
    if (cpu_limit == 0) return 1;
    if (cpu_limit > pjd_pkg::Cpus) return pjd_pkg::Cpus;
    return int'(cpu_limit);
  endfunction

  function automatic res_t mk(logic st, logic [3:0] c, logic [7:0] j, logic d, logic b);
    res_t r;
    r.started = st; r.cpu = c; r.job = j; r.dropped = d; r.bad = b;
    r.pend = 5'(waitq.size()); r.act = 5'(act_n); r.last = 1'b0;
    return r;
  endfunction

  // Apply one command to the predictor and queue its results.
  task automatic predict_dispatch(cmd_t c);
    logic d, b, run;
    int n, nc, slot, best;
    pjd_pkg::entry_t e;
    bit ok;
    d = 0; b = 0; n = 0;
    if (c.cmd == pjd_pkg::CmdSubmit) begin
      if (waitq.size() >= pjd_pkg::PendDepth) d = 1;
      else begin
        e.job = c.job; e.prio = c.prio; e.has_pref = c.has_pref; e.pref = c.pref;
        waitq.insert(waitq.size(), e);
      end
      run = c.blast;
    end else begin
      if (slot_on[c.fcpu]) begin
        slot_on[c.fcpu] = 0; act_n--;
      end else b = 1;
      run = 1;
    end
    nc = eff_cpus();
    while (run && waitq.size() > 0) begin
      ok = 0; slot = 0;
      for (int i = nc - 1; i >= 0; i--) if (!slot_on[i]) begin slot = i; ok = 1; end
      if (!ok) break;
      best = 0;
      for (int i = 1; i < waitq.size(); i++) if (waitq[i].prio > waitq[best].prio) best = i;
      e = waitq[best];
      if (e.has_pref && e.pref < nc && !slot_on[e.pref]) slot = e.pref;
      waitq.delete(best);
      slot_on[slot] = 1; act_n++;
      expected_q.insert(expected_q.size(), mk(1'b1, 4'(slot), e.job, d, b));
      n++;
    end
    if (n == 0) expected_q.insert(expected_q.size(), mk(1'b0, 4'd0, 8'd0, d, b));
    expected_q[expected_q.size() - 1].last = 1'b1;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    res_t got, w;
    cycles <= cycles + 1;
    if (rst_ni && strobe_o) begin
      got = {started_o, start_cpu_o, start_job_id_o, dropped_o, bad_finish_o,
             pending_count_o, active_count_o, last_o};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        w = expected_q.pop_front();
        if (w !== got) begin
          errors++;
          if (errors <= 10) $display("mismatch exp %h got %h", w, got);
        end
      end
    end
  end

  bit quiet = 0;

  // chk: the last result of this transaction is the typed-in exp
  task automatic send(cmd_t c, logic chk = 1'b0, res_t exp = '0);
    if (!quiet && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_dispatch(c);
    if (chk) expected_q[expected_q.size() - 1] = exp;
    start <= 1'b1;
    {cmd_i, job_id_i, priority_req_i, has_preference_i, preferred_cpu_i,
     batch_last_i, finished_cpu_i} <= c;
    @(posedge clk_i);
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle_and_config(logic [4:0] v);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    num_cpus_we_i <= 1'b1;
    num_cpus_i    <= v;
    cpu_limit      = v;
    @(posedge clk_i);
    num_cpus_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic cmd_t sub(logic [7:0] j, logic [7:0] p, logic hp, logic [3:0] pc,
                               logic bl);
    return {pjd_pkg::CmdSubmit, j, p, hp, pc, bl, 4'($urandom)};
  endfunction

  function automatic cmd_t fin(logic [3:0] f);
    return {pjd_pkg::CmdFinish, 8'($urandom), 8'($urandom), 1'($urandom), 4'($urandom),
            1'($urandom), f};
  endfunction

  function automatic row_t plain(cmd_t c);
    return '{c: c, chk: 1'b0, exp: '0};
  endfunction

  function automatic row_t typed(cmd_t c, res_t r);
    return '{c: c, chk: 1'b1, exp: r};
  endfunction

  // Directed table.
  row_t dir_tab[] = '{
    // bad finish after reset
    typed(fin(4'd0), '{started: 1'b0, cpu: 4'd0, job: 8'd0, dropped: 1'b0, bad: 1'b1,
                       pend: 5'd0, act: 5'd0, last: 1'b1}),
    // lowest priority, stored only
    typed(sub(8'hFF, 8'h00, 1, 4'd15, 0),
          '{started: 1'b0, cpu: 4'd0, job: 8'd0, dropped: 1'b0, bad: 1'b0,
            pend: 5'd1, act: 5'd0, last: 1'b1}),
    plain(sub(8'h00, 8'hFF, 0, 4'd0, 0)),
    plain(sub(8'h11, 8'h80, 1, 4'd3, 0)), plain(sub(8'h12, 8'h80, 1, 4'd3, 1)),  // tie, pref
    plain(fin(4'd3)), plain(fin(4'd3)), plain(fin(4'd15)), plain(fin(4'd0)), plain(fin(4'd1))
  };

  cmd_t c;
  initial begin
    foreach (slot_on[i]) slot_on[i] = 0;
    cpu_limit = 5'd16; act_n = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) send(dir_tab[i].c, dir_tab[i].chk, dir_tab[i].exp);
    // Fill the store past full, then one dropped batch end.
    settle_and_config(5'd1);
    for (int i = 0; i < 17; i++) send(sub(8'(i), 8'($urandom), 1, 4'd9, 0));
    send(sub(8'h55, 8'h01, 0, 0, 1));
    send(fin(4'd0));
    settle_and_config(5'd0);
    send(fin(4'd0));
    settle_and_config(5'd31);
    send(fin(4'd0));
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: settle_and_config(5'd16);
        1: settle_and_config(5'd4);
        2: settle_and_config(5'd1);
        3: settle_and_config(5'($urandom_range(2, 15)));
        default: begin settle_and_config(5'd16); quiet = 1; end
      endcase
      for (int k = 0; k < 46; k++) begin
        if ($urandom_range(0, 2) == 0) c = fin(4'($urandom_range(0, 15)));
        else c = sub(8'($urandom), 8'($urandom), 1'($urandom), 4'($urandom),
                     $urandom_range(0, 3) == 0);
        send(c);
      end
    end
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  // Timeout.
  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("tb: done, errors");
      $finish;
    end
  end
endmodule

// ===== filelist.f =====
src/pjd_pkg.sv
src/pjd_cell.sv
src/pjd_chain.sv
src/priority_job_dispatcher.sv
tb/sv/tb.sv
